// ===== src/plt_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table package
// Shared beat types, operation and status codes, sequencer states and sizing
// defaults for the positional list table core.
// ----------------------------------------------------------------------------
package plt_pkg;

   localparam int MAX_ENTRIES_DEFAULT = 16;

   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_DELETE = 3'd1;
   localparam logic [2:0] OP_SET    = 3'd2;
   localparam logic [2:0] OP_FIND   = 3'd3;
   localparam logic [2:0] OP_GET    = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [2:0]          req_type;
      logic [4:0]          position;
      logic signed [31:0]  value;
   } req_beat_type;

   typedef struct packed {
      logic [1:0]          status;
      logic signed [31:0]  read_value;
      logic                found;
      logic [3:0]          found_index;
      logic [4:0]          entry_count;
   } rsp_beat_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_INS_WRITE,
      S_SHIFT_DOWN,
      S_FIND,
      S_GET_WAIT
   } state_type;

endpackage

// ===== src/positional_list_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table core
// Ordered list of signed words kept in a table with one read and one write port and an entry
// count, driven by a small sequencer that moves one entry per cycle.
// ----------------------------------------------------------------------------
// A request beat is taken when start is high and busy is low, and its single
// result appears on rsp_data for one cycle with rsp_valid high; the receiver
// cannot stall it. Every entry movement and every comparison goes through the
// one read and one write port of the table, one entry per cycle. An insert in
// range moves entries from its position on up in S_SHIFT_UP and writes the
// value in S_INS_WRITE, or writes it directly when it appends; a delete moves
// later entries down in S_SHIFT_DOWN; a find reads from index 0 in S_FIND until
// a match or the end; a get answers from S_GET_WAIT; others answer from idle.
// busy stays high until the result has been issued.
module positional_list_table_core
   import plt_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  req_beat_type  req_data,
   output logic          rsp_valid,
   output rsp_beat_type  rsp_data
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int PW = (CW > 5) ? CW : 5;
   localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_ENTRIES);

   logic signed [31:0] entries_mem [MAX_ENTRIES];

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [PW-1:0]      idx_ff, idx_in;
   req_beat_type       req_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_beat_type       rsp_ff, rsp_in;
   logic signed [31:0] rd_data_ff;

   logic               rd_en;
   logic [AW-1:0]      rd_addr;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;

   logic               accept;
   logic [PW-1:0]      cnt_ext;
   logic [PW-1:0]      cnt_dec;
   logic [PW-1:0]      pos_new;
   logic [PW-1:0]      pos_new_inc;
   logic [PW-1:0]      pos_held;
   logic [PW-1:0]      idx_dec;
   logic [PW-1:0]      idx_dec2;
   logic [PW-1:0]      idx_inc;
   logic [PW-1:0]      idx_inc2;

   assign accept      = start && (state_ff == S_IDLE);
   assign busy        = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_data    = rsp_ff;

   assign cnt_ext     = PW'(count_ff);
   assign cnt_dec     = cnt_ext - PW'(1);
   assign pos_new     = PW'(req_data.position);
   assign pos_new_inc = pos_new + PW'(1);
   assign pos_held    = PW'(req_ff.position);
   assign idx_dec     = idx_ff - PW'(1);
   assign idx_dec2    = idx_ff - PW'(2);
   assign idx_inc     = idx_ff + PW'(1);
   assign idx_inc2    = idx_ff + PW'(2);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      rsp_ff <= rsp_in;
      if (accept) begin
         req_ff <= req_data;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= entries_mem[rd_addr];
      end
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rd_en        = 1'b0;
      rd_addr      = idx_ff[AW-1:0];
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               case (req_data.req_type)
                  OP_INSERT: begin
                     if (pos_new > cnt_ext) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (count_ff == MAX_COUNT) begin
                        rsp_in.status = STATUS_FULL;
                        rsp_valid_in  = 1'b1;
                     end else if (pos_new == cnt_ext) begin
                        wr_en        = 1'b1;
                        wr_addr      = pos_new[AW-1:0];
                        wr_data      = req_data.value;
                        count_in     = count_ff + CW'(1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = cnt_dec[AW-1:0];
                        idx_in   = cnt_ext;
                        state_in = S_SHIFT_UP;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_new >= cnt_ext) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else if (pos_new_inc == cnt_ext) begin
                        count_in     = count_ff - CW'(1);
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_new_inc[AW-1:0];
                        idx_in   = pos_new;
                        state_in = S_SHIFT_DOWN;
                     end
                  end
                  OP_SET: begin
                     if (pos_new >= cnt_ext) begin
                        rsp_in.status = STATUS_RANGE;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pos_new[AW-1:0];
                        wr_data = req_data.value;
                     end
                     rsp_valid_in = 1'b1;
                  end
                  OP_FIND: begin
                     if (count_ff == '0) begin
                        rsp_valid_in = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = '0;
                        idx_in   = '0;
                        state_in = S_FIND;
                     end
                  end
                  OP_GET: begin
                     if (pos_new >= cnt_ext) begin
                        rsp_in.status = STATUS_RANGE;
                        rsp_valid_in  = 1'b1;
                     end else begin
                        rd_en    = 1'b1;
                        rd_addr  = pos_new[AW-1:0];
                        state_in = S_GET_WAIT;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SHIFT_UP: begin
            wr_en = 1'b1;
            if (idx_dec == pos_held) begin
               state_in = S_INS_WRITE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_dec2[AW-1:0];
               idx_in  = idx_dec;
            end
         end
         S_INS_WRITE: begin
            wr_en        = 1'b1;
            wr_addr      = pos_held[AW-1:0];
            wr_data      = req_ff.value;
            count_in     = count_ff + CW'(1);
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_SHIFT_DOWN: begin
            wr_en = 1'b1;
            if (idx_inc2 < cnt_ext) begin
               rd_en   = 1'b1;
               rd_addr = idx_inc2[AW-1:0];
               idx_in  = idx_inc;
            end else begin
               count_in     = count_ff - CW'(1);
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_FIND: begin
            if (rd_data_ff == req_ff.value) begin
               rsp_in.found       = 1'b1;
               rsp_in.found_index = 4'(idx_ff);
               rsp_valid_in       = 1'b1;
               state_in           = S_IDLE;
            end else if (idx_inc == cnt_ext) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en   = 1'b1;
               rd_addr = idx_inc[AW-1:0];
               idx_in  = idx_inc;
            end
         end
         S_GET_WAIT: begin
            rsp_in.read_value = rd_data_ff;
            rsp_valid_in      = 1'b1;
            state_in          = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_in.entry_count = 5'(count_in);
   end

`ifndef ASSERT_OFF
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_COUNT)
      else $error("entry count exceeds table capacity");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      accept |=> (busy || rsp_valid))
      else $error("accepted beat neither started work nor produced a result");

   a_rsp_only_on_finish: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result issued while sequencer still busy");

   a_found_is_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == STATUS_OK))
      else $error("find hit reported with an error status");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (count_ff != $past(count_ff)) |-> rsp_valid_in || rsp_valid)
      else $error("entry count changed outside a request completion");
`endif

endmodule

// ===== tb/tb_positional_list_table_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Positional list table core testbench
// Drives insert, delete, set, find, get and reserved request beats through
// the start/busy handshake in bursts with random gaps. A scoreboard keeps its
// own copy of the list, predicts every result beat and compares each field of
// the strobed results in order.
// ----------------------------------------------------------------------------
module tb_positional_list_table_core;
   import plt_pkg::*;

   localparam int TABLE_DEPTH = MAX_ENTRIES_DEFAULT;
   localparam int RANDOM_BEATS = 1200;
   localparam logic [2:0] OP_RESERVED_FIRST = 3'd5;
   localparam logic [2:0] OP_RESERVED_LAST  = 3'd7;

   class list_table_scoreboard;
      logic signed [31:0] cells [TABLE_DEPTH];
      int                 used;
      rsp_beat_type       expected_rsp [$];
      int                 errors;

      function new();
         used = 0;
         errors = 0;
      endfunction

      function void note_request(req_beat_type req);
         rsp_beat_type rsp;
         int           pos;
         int           i;
         rsp = '0;
         pos = int'(req.position);
         case (req.req_type)
            OP_INSERT: begin
               if (pos > used) begin
                  rsp.status = STATUS_RANGE;
               end else if (used >= TABLE_DEPTH) begin
                  rsp.status = STATUS_FULL;
               end else begin
                  for (i = used; i > pos; i--) cells[i] = cells[i - 1];
                  cells[pos] = req.value;
                  used++;
               end
            end
            OP_DELETE: begin
               if (pos >= used) begin
                  rsp.status = STATUS_RANGE;
               end else begin
                  for (i = pos; i + 1 < used; i++) cells[i] = cells[i + 1];
                  used--;
               end
            end
            OP_SET: begin
               if (pos >= used) rsp.status = STATUS_RANGE;
               else cells[pos] = req.value;
            end
            OP_FIND: begin
               for (i = 0; i < used; i++) begin
                  if (cells[i] == req.value) begin
                     rsp.found = 1'b1;
                     rsp.found_index = i[3:0];
                     break;
                  end
               end
            end
            OP_GET: begin
               if (pos >= used) rsp.status = STATUS_RANGE;
               else rsp.read_value = cells[pos];
            end
            default: begin
            end
         endcase
         rsp.entry_count = used[4:0];
         expected_rsp.push_back(rsp);
      endfunction

      function void check_response(rsp_beat_type got);
         rsp_beat_type want;
         if (expected_rsp.size() == 0) begin
            $error("result beat with no request outstanding");
            errors++;
            return;
         end
         want = expected_rsp.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            errors++;
         end
         if (got.read_value !== want.read_value) begin
            $error("read_value: expected %0d, actual %0d", want.read_value, got.read_value);
            errors++;
         end
         if (got.found !== want.found) begin
            $error("found: expected %0d, actual %0d", want.found, got.found);
            errors++;
         end
         if (got.found_index !== want.found_index) begin
            $error("found_index: expected %0d, actual %0d", want.found_index,
                   got.found_index);
            errors++;
         end
         if (got.entry_count !== want.entry_count) begin
            $error("entry_count: expected %0d, actual %0d", want.entry_count,
                   got.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         start;
   logic         busy;
   req_beat_type req_data;
   logic         rsp_valid;
   rsp_beat_type rsp_data;

   list_table_scoreboard sb = new();

   positional_list_table_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) sb.check_response(rsp_data);
         if (start && !busy) sb.note_request(req_data);
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_request(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
      req_beat_type beat;
      beat.req_type = op;
      beat.position = pos;
      beat.value = val;
      start <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   task automatic pause_requests(int cycles);
      logic [63:0] noise;
      noise = {$urandom, $urandom};
      start <= 1'b0;
      req_data <= noise[$bits(req_beat_type)-1:0];
      repeat (cycles) @(negedge clock);
   endtask

   function automatic req_beat_type random_request(bit growing);
      req_beat_type beat;
      int           roll;
      int           insert_share;
      int           delete_share;
      roll = $urandom_range(0, 99);
      insert_share = growing ? 40 : 12;
      delete_share = growing ? 10 : 38;
      beat.value = $urandom;
      beat.position = 5'($urandom_range(0, 31));
      if (roll < 4) beat.req_type = 3'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
      else if (roll < 4 + insert_share) beat.req_type = OP_INSERT;
      else if (roll < 54) beat.req_type = OP_DELETE;
      else if (roll < 66) beat.req_type = OP_SET;
      else if (roll < 84) beat.req_type = OP_FIND;
      else beat.req_type = OP_GET;
      if (beat.req_type == OP_INSERT) begin
         if ($urandom_range(0, 9) != 0) beat.position = 5'($urandom_range(0, sb.used));
      end else if (sb.used > 0 && $urandom_range(0, 9) != 0) begin
         beat.position = 5'($urandom_range(0, sb.used - 1));
      end
      if (sb.used > 0) begin
         if ((beat.req_type == OP_FIND && $urandom_range(0, 2) != 0) ||
             ((beat.req_type == OP_INSERT || beat.req_type == OP_SET) &&
              $urandom_range(0, 3) == 0)) begin
            beat.value = sb.cells[$urandom_range(0, sb.used - 1)];
         end
      end
      return beat;
   endfunction

   initial begin
      req_beat_type beat;
      int           sent;
      int           burst;
      int           phase_left;
      bit           growing;

      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Empty table: every positional request is out of range.
      send_request(OP_GET, 5'd0, 32'sd0);
      send_request(OP_DELETE, 5'd0, 32'sd0);
      send_request(OP_SET, 5'd0, 32'sd5);
      send_request(OP_FIND, 5'd0, 32'sd0);
      send_request(OP_INSERT, 5'd1, 32'sd7);
      send_request(OP_RESERVED_FIRST, 5'd31, -32'sd1);
      send_request(OP_RESERVED_FIRST + 3'd1, 5'd0, 32'sd0);
      send_request(OP_RESERVED_LAST, 5'd16, 32'sd9);

      send_request(OP_INSERT, 5'd0, 32'sh8000_0000);
      send_request(OP_INSERT, 5'd1, 32'sh7FFF_FFFF);
      send_request(OP_INSERT, 5'd1, -32'sd1);
      send_request(OP_INSERT, 5'd0, 32'sd0);
      send_request(OP_FIND, 5'd0, 32'sh7FFF_FFFF);
      send_request(OP_FIND, 5'd31, -32'sd1);
      send_request(OP_FIND, 5'd0, 32'sd12345);
      send_request(OP_GET, 5'd1, 32'sd0);
      send_request(OP_SET, 5'd2, 32'sd0);
      send_request(OP_FIND, 5'd0, 32'sd0);
      send_request(OP_GET, 5'd4, 32'sd0);
      send_request(OP_DELETE, 5'd3, 32'sd0);
      send_request(OP_DELETE, 5'd0, 32'sd0);
      send_request(OP_INSERT, 5'd31, 32'sd1);
      send_request(OP_SET, 5'd31, 32'sd1);
      send_request(OP_GET, 5'd31, 32'sd0);
      send_request(OP_DELETE, 5'd31, 32'sd0);

      // Fill the table, then probe the full and out-of-range precedence.
      while (sb.used < TABLE_DEPTH) begin
         send_request(OP_INSERT, 5'($urandom_range(0, sb.used)), $urandom);
      end
      send_request(OP_INSERT, 5'd0, 32'sd3);
      send_request(OP_INSERT, 5'd16, 32'sd3);
      send_request(OP_INSERT, 5'd17, 32'sd3);
      send_request(OP_GET, 5'd15, 32'sd0);
      send_request(OP_FIND, 5'd0, sb.cells[TABLE_DEPTH - 1]);
      send_request(OP_DELETE, 5'd15, 32'sd0);
      send_request(OP_DELETE, 5'd0, 32'sd0);
      pause_requests(3);

      sent = 0;
      growing = 1'b1;
      phase_left = $urandom_range(20, 80);
      while (sent < RANDOM_BEATS) begin
         burst = $urandom_range(1, 40);
         repeat (burst) begin
            beat = random_request(growing);
            send_request(beat.req_type, beat.position, beat.value);
            if (beat.req_type <= OP_GET) sent++;
            phase_left--;
            if (phase_left <= 0) begin
               growing = !growing;
               phase_left = $urandom_range(20, 80);
            end
         end
         if ($urandom_range(0, 3) != 0) pause_requests($urandom_range(1, 8));
      end
      pause_requests(1);

      while (sb.expected_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (sb.errors == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
